// ===== rtl/mrb_pkg.sv =====
// Shared types, printer command codes and limits for the raster-to-band converter.
package mrb_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int BAND_ROWS     = 24;
    localparam int CFG_DW        = 16;

    localparam logic [7:0] ESC_CODE    = 8'h1b;
    localparam logic [7:0] STAR_CODE   = 8'h2a;
    localparam logic [7:0] MODE_CODE   = 8'h21;
    localparam logic [7:0] LF_CODE     = 8'h0a;
    localparam logic [7:0] SPACE3_CODE = 8'h33;
    localparam logic [7:0] PITCH_CODE  = 8'h18;

    localparam logic [10:0] WIDTH_RESET  = 11'd512;
    localparam logic [15:0] HEIGHT_RESET = 16'd24;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_HEIGHT = 2'd1;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_PULL  = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] pixel_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       band_end;
        logic       image_end;
    } t_out;

    function automatic logic [7:0] prologue_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = ESC_CODE;
            2'd1:    b = SPACE3_CODE;
            2'd2:    b = PITCH_CODE;
            default: b = LF_CODE;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/mrb_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module mrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 3072
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mono_raster_to_24pin_band.sv =====
// Top level: raster byte intake, 24-row band transpose store and printer byte stream.
// A pixel beat does eight read-modify-writes of the band store, pipelined on its single read
// and single write port, between its entry and exit steps.
// A pull beat that returns a command byte gives its strobe in the cycle after acceptance;
// a pull that returns a column byte needs one store read and strobes from the S_PULL state.
// After reset, and after every register write, the band store is swept to zero, all
// 3 * MAX_WIDTH bytes, with busy high; the results are never stalled by the receiver.
module mono_raster_to_24pin_band #(
    parameter int MAX_WIDTH = mrb_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  mrb_pkg::t_in                i_in,
    output logic                        o_strobe,
    output mrb_pkg::t_out               o_out,
    input  logic                        i_cfg_we,
    input  mrb_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [mrb_pkg::CFG_DW-1:0]  i_cfg_data
);

    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(DEPTH + 6);
    localparam int BW    = $clog2(MAX_WIDTH / 8 + 1);
    localparam int CAP   = (MAX_WIDTH / 8) * 8;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_PIX, S_PULL} t_state;
    typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_DONE} t_phase;

    t_state            r_state;
    t_phase            r_phase;
    logic              r_pro_sent;
    logic [PW-1:0]     r_pos;
    logic [4:0]        r_row;
    logic [BW-1:0]     r_bir;
    logic [AW-1:0]     r_byte_base;
    logic [16:0]       r_band_base;
    logic [AW-1:0]     r_clr;
    logic [3:0]        r_k;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_waddr;
    logic [7:0]        r_pix;
    logic              r_blk;
    logic [7:0]        r_dot;
    logic [10:0]       r_cfg_w;
    logic [15:0]       r_cfg_h;
    logic [10:0]       r_eff_w;
    logic [15:0]       r_eff_h;
    logic [PW-1:0]     r_len;
    logic              r_strobe;
    mrb_pkg::t_out     r_out;

    logic [10:0]       n_eff_w;
    logic [10:0]       w_mask;
    logic [PW-1:0]     n_len;
    logic [15:0]       n_eff_h;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;

    logic              accept;
    logic [PW-1:0]     pos_m5;
    logic [11:0]       bir_next;
    logic [4:0]        row_next;
    logic              row_wrap;
    logic              band_full;
    logic              last_band;

    always_comb begin
        w_mask = r_cfg_w & 11'h7f8;
        if (int'(w_mask) > CAP) begin
            n_eff_w = 11'(CAP);
        end else if (w_mask < 11'd8) begin
            n_eff_w = 11'd8;
        end else begin
            n_eff_w = w_mask;
        end
        n_len   = PW'({r_eff_w, 1'b0}) + PW'(r_eff_w) + PW'(5);
        n_eff_h = (r_cfg_h == 16'd0) ? 16'd1 : r_cfg_h;
    end

    assign accept    = start && (r_state == S_IDLE);
    assign busy      = (r_state != S_IDLE);
    assign pos_m5    = r_pos - PW'(5);
    assign bir_next  = 12'(r_bir) + 12'd1;
    assign row_wrap  = (bir_next >= {4'd0, r_eff_w[10:3]});
    assign row_next  = r_row + 5'd1;
    assign band_full = (row_next >= 5'(mrb_pkg::BAND_ROWS))
                    || ((r_band_base + 17'(row_next)) >= {1'b0, r_eff_h});
    assign last_band = ({1'b0, r_band_base} + 18'(mrb_pkg::BAND_ROWS)) >= {2'b00, r_eff_h};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = 8'h00;
        ram_raddr = r_addr;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_PIX: begin
                ram_we    = (r_k != 4'd0);
                ram_waddr = r_waddr;
                ram_wdata = ram_rdata | (r_blk ? r_dot : 8'h00);
            end
            S_PULL: begin
                ram_we    = 1'b1;
                ram_waddr = r_waddr;
            end
            S_IDLE: begin
                ram_raddr = pos_m5[AW-1:0];
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    mrb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_phase     <= PH_FILL;
            r_pro_sent  <= 1'b0;
            r_pos       <= '0;
            r_row       <= '0;
            r_bir       <= '0;
            r_byte_base <= '0;
            r_band_base <= '0;
            r_clr       <= '0;
            r_k         <= '0;
            r_cfg_w     <= mrb_pkg::WIDTH_RESET;
            r_cfg_h     <= mrb_pkg::HEIGHT_RESET;
            r_eff_w     <= mrb_pkg::WIDTH_RESET;
            r_eff_h     <= mrb_pkg::HEIGHT_RESET;
            r_len       <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_eff_w  <= n_eff_w;
            r_eff_h  <= n_eff_h;
            r_len    <= n_len;
            r_strobe <= 1'b0;

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept && i_in.mode == mrb_pkg::MODE_PIXEL) begin
                        if (r_phase == PH_FILL) begin
                            r_state <= S_PIX;
                            r_k     <= '0;
                            r_addr  <= r_byte_base + AW'(r_row[4:3]);
                            r_pix   <= ~i_in.pixel_byte;
                            r_dot   <= 8'h80 >> r_row[2:0];
                            if (row_wrap) begin
                                r_bir       <= '0;
                                r_byte_base <= '0;
                                r_row       <= row_next;
                                if (band_full) begin
                                    r_phase <= PH_DRAIN;
                                end
                            end else begin
                                r_bir       <= bir_next[BW-1:0];
                                r_byte_base <= r_byte_base + AW'(mrb_pkg::BAND_ROWS);
                            end
                        end
                    end else if (accept && r_phase != PH_DONE) begin
                        if (!r_pro_sent) begin
                            r_strobe        <= 1'b1;
                            r_out.out_byte  <= mrb_pkg::prologue_byte(r_pos[1:0]);
                            r_out.band_end  <= 1'b0;
                            r_out.image_end <= 1'b0;
                            if (r_pos[1:0] == 2'd3) begin
                                r_pos      <= '0;
                                r_pro_sent <= 1'b1;
                            end else begin
                                r_pos <= r_pos + PW'(1);
                            end
                        end else if (r_phase == PH_DRAIN) begin
                            r_out.band_end  <= 1'b0;
                            r_out.image_end <= 1'b0;
                            if (r_pos < PW'(5)) begin
                                r_strobe <= 1'b1;
                                r_pos    <= r_pos + PW'(1);
                                case (r_pos[2:0])
                                    3'd0:    r_out.out_byte <= mrb_pkg::ESC_CODE;
                                    3'd1:    r_out.out_byte <= mrb_pkg::STAR_CODE;
                                    3'd2:    r_out.out_byte <= mrb_pkg::MODE_CODE;
                                    3'd3:    r_out.out_byte <= r_eff_w[7:0];
                                    default: r_out.out_byte <= {5'd0, r_eff_w[10:8]};
                                endcase
                            end else if (r_pos < r_len) begin
                                r_state <= S_PULL;
                                r_waddr <= pos_m5[AW-1:0];
                                r_pos   <= r_pos + PW'(1);
                            end else begin
                                r_strobe        <= 1'b1;
                                r_out.out_byte  <= mrb_pkg::LF_CODE;
                                r_out.band_end  <= 1'b1;
                                r_out.image_end <= last_band;
                                r_pos           <= '0;
                                r_row           <= '0;
                                r_bir           <= '0;
                                r_byte_base     <= '0;
                                r_band_base     <= r_band_base + 17'(mrb_pkg::BAND_ROWS);
                                r_phase         <= last_band ? PH_DONE : PH_FILL;
                            end
                        end
                    end
                end
                S_PIX: begin
                    r_k <= r_k + 4'd1;
                    if (r_k != 4'd8) begin
                        r_addr  <= r_addr + AW'(3);
                        r_waddr <= r_addr;
                        r_blk   <= r_pix[7];
                        r_pix   <= {r_pix[6:0], 1'b0};
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PULL: begin
                    r_strobe        <= 1'b1;
                    r_out.out_byte  <= ram_rdata;
                    r_out.band_end  <= 1'b0;
                    r_out.image_end <= 1'b0;
                    r_state         <= S_IDLE;
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase

            if (i_cfg_we && (i_cfg_idx == mrb_pkg::CFG_WIDTH
                          || i_cfg_idx == mrb_pkg::CFG_HEIGHT)) begin
                if (i_cfg_idx == mrb_pkg::CFG_WIDTH) begin
                    r_cfg_w <= i_cfg_data[10:0];
                end else begin
                    r_cfg_h <= i_cfg_data[15:0];
                end
                r_state     <= S_CLEAR;
                r_clr       <= '0;
                r_phase     <= PH_FILL;
                r_pro_sent  <= 1'b0;
                r_pos       <= '0;
                r_row       <= '0;
                r_bir       <= '0;
                r_byte_base <= '0;
                r_band_base <= '0;
                r_strobe    <= 1'b0;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule

// ===== rtl/mrb_checker.sv =====
// Port-level checks for the raster-to-band converter, bound to its top level.
module mrb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input mrb_pkg::t_in               i_in,
    input logic                       o_strobe,
    input mrb_pkg::t_out              o_out
);

    a_image_end_on_band_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.image_end) |-> o_out.band_end)
        else $error("image end beat without band end");

    a_band_end_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.band_end) |-> (o_out.out_byte == mrb_pkg::LF_CODE))
        else $error("band end beat is not a line feed");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> busy)
        else $error("store clear did not start after reset");

    a_strobe_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) || $past(start && !busy && i_in.mode == mrb_pkg::MODE_PULL)))
        else $error("result beat without a preceding pull");

endmodule

bind mono_raster_to_24pin_band mrb_checker u_mrb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_in     (i_in),
    .o_strobe (o_strobe),
    .o_out    (o_out)
);

// ===== test/tb_mono_raster_to_24pin_band.sv =====
// Self-checking testbench for the raster-to-band converter.
`timescale 1ns / 100ps

module tb_mono_raster_to_24pin_band;
    import mrb_pkg::*;

    localparam int MAXW = MAX_WIDTH_DEF;
    localparam int STORE_DEPTH = 3 * MAXW;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_TARGET = 600;
    localparam int unsigned NO_CAP = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {FILLING, DRAINING, IMAGE_DONE} t_fill_phase;

    class band_stream_model;
        logic [10:0] width_reg;
        logic [15:0] height_reg;
        logic [7:0]  columns [STORE_DEPTH];
        int unsigned row_in_band;
        int unsigned byte_in_row;
        int unsigned band_no;
        int unsigned out_pos;
        t_fill_phase phase;
        bit          prologue_done;
        t_out        want_q[$];
        int          mismatches;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            foreach (columns[i]) columns[i] = 8'h00;
            row_in_band   = 0;
            byte_in_row   = 0;
            band_no       = 0;
            out_pos       = 0;
            phase         = FILLING;
            prologue_done = 1'b0;
        endfunction

        function int unsigned dots();
            int unsigned w;
            w = width_reg & 11'h7F8;
            if (w > (MAXW & ~7)) w = MAXW & ~7;
            if (w < 8) w = 8;
            return w;
        endfunction

        function int unsigned rows_total();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function void load_reg(t_cfg_idx idx, logic [CFG_DW-1:0] data);
            if (idx == CFG_WIDTH) width_reg = data[10:0];
            else if (idx == CFG_HEIGHT) height_reg = data[15:0];
            else return;
            restart();
        endfunction

        function void take_beat(t_in beat);
            t_out        r;
            int unsigned w;
            int unsigned p;
            int unsigned col;
            int unsigned idx;
            int unsigned sub;
            logic [7:0]  dot;
            w = dots();
            r = '0;
            if (beat.mode == MODE_PIXEL) begin
                if (phase == FILLING) begin
                    dot = 8'h80 >> (row_in_band % 8);
                    sub = (row_in_band / 8) % 4;
                    for (int k = 0; k < 8; k++) begin
                        col = byte_in_row * 8 + k;
                        idx = col * 3 + sub;
                        if (!beat.pixel_byte[7-k] && idx < STORE_DEPTH) columns[idx] |= dot;
                    end
                    byte_in_row++;
                    if (byte_in_row >= w / 8) begin
                        byte_in_row = 0;
                        row_in_band++;
                        if (row_in_band >= BAND_ROWS ||
                            band_no * BAND_ROWS + row_in_band >= rows_total())
                            phase = DRAINING;
                    end
                end
                return;
            end
            if (phase == IMAGE_DONE) return;
            if (!prologue_done) begin
                case (out_pos)
                    0: r.out_byte = ESC_CODE;
                    1: r.out_byte = SPACE3_CODE;
                    2: r.out_byte = PITCH_CODE;
                    default: r.out_byte = LF_CODE;
                endcase
                out_pos++;
                if (out_pos >= 4) begin
                    out_pos = 0;
                    prologue_done = 1'b1;
                end
            end else if (phase == FILLING) begin
                return;
            end else begin
                p = out_pos;
                if (p == 0) r.out_byte = ESC_CODE;
                else if (p == 1) r.out_byte = STAR_CODE;
                else if (p == 2) r.out_byte = MODE_CODE;
                else if (p == 3) r.out_byte = w[7:0];
                else if (p == 4) r.out_byte = w[15:8];
                else if (p < 5 + 3 * w) begin
                    idx = p - 5;
                    if (idx < STORE_DEPTH) begin
                        r.out_byte = columns[idx];
                        columns[idx] = 8'h00;
                    end
                end else begin
                    r.out_byte  = LF_CODE;
                    r.band_end  = 1'b1;
                    r.image_end = ((band_no + 1) * BAND_ROWS >= rows_total());
                end
                if (r.band_end) begin
                    out_pos     = 0;
                    row_in_band = 0;
                    byte_in_row = 0;
                    phase       = r.image_end ? IMAGE_DONE : FILLING;
                    band_no     = (band_no + 1) % 4096;
                end else begin
                    out_pos++;
                end
            end
            want_q.push_back(r);
        endfunction

        function void check_byte(t_out got);
            t_out want;
            if (want_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: byte %02h band_end %0b image_end %0b",
                             got.out_byte, got.band_end, got.image_end);
                return;
            end
            want = want_q.pop_front();
            if (got.out_byte !== want.out_byte || got.band_end !== want.band_end ||
                got.image_end !== want.image_end) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                             want.out_byte, want.band_end, want.image_end,
                             got.out_byte, got.band_end, got.image_end);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_in               i_in = '0;
    logic              o_strobe;
    t_out              o_out;
    logic              i_cfg_we = 1'b0;
    t_cfg_idx          i_cfg_idx = CFG_WIDTH;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    band_stream_model printer_stream = new();
    int               beats_counted = 0;
    bit               gaps_on = 1'b0;
    int               quiet_cycles = 0;

    mono_raster_to_24pin_band i_dut (
        .i_clk,
        .i_rst_n,
        .start,
        .busy,
        .i_in,
        .o_strobe,
        .o_out,
        .i_cfg_we,
        .i_cfg_idx,
        .i_cfg_data
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) printer_stream.check_byte(o_out);
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] pixel_pattern();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic send_beat(input logic kind, input logic [7:0] pix);
        t_in beat;
        beat.mode = kind;
        beat.pixel_byte = pix;
        start <= 1'b1;
        i_in <= beat;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        printer_stream.take_beat(beat);
        beats_counted++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // A pixel beat can still be in flight after the last result, so allow its latency.
    task automatic settle();
        start <= 1'b0;
        while (printer_stream.want_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_DW-1:0] data);
        while (busy !== 1'b0) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        printer_stream.load_reg(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        do @(posedge i_clk); while (busy !== 1'b1);
    endtask

    task automatic configure(input logic [10:0] w, input logic [15:0] h);
        logic [CFG_DW-1:0] wdata;
        wdata = CFG_DW'($urandom());
        wdata[10:0] = w;
        settle();
        if ($urandom_range(0, 1)) begin
            write_cfg(CFG_WIDTH, wdata);
            write_cfg(CFG_HEIGHT, h);
        end else begin
            write_cfg(CFG_HEIGHT, h);
            write_cfg(CFG_WIDTH, wdata);
        end
    endtask

    // Fills and drains up to band_cap bands; a drain that reaches drain_cap pulls is cut there and ends the run.
    task automatic run_image(input int unsigned band_cap, input int unsigned drain_cap);
        int unsigned w;
        int unsigned h;
        int unsigned bands;
        int unsigned rows;
        int unsigned pro_left;
        int unsigned pulls;
        w = printer_stream.dots();
        h = printer_stream.rows_total();
        bands = (h + BAND_ROWS - 1) / BAND_ROWS;
        pro_left = 4;
        for (int unsigned b = 0; b < bands && b < band_cap; b++) begin
            rows = (h - b * BAND_ROWS > BAND_ROWS) ? BAND_ROWS : h - b * BAND_ROWS;
            for (int unsigned i = 0; i < rows * (w / 8); i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_beat(MODE_PULL, 8'($urandom()));
                    if (pro_left > 0) pro_left--;
                end
                send_beat(MODE_PIXEL, pixel_pattern());
            end
            pulls = 3 * w + 6 + pro_left;
            pro_left = 0;
            if (pulls > drain_cap) pulls = drain_cap;
            for (int unsigned i = 0; i < pulls; i++) begin
                if ($urandom_range(0, 15) == 0) send_beat(MODE_PIXEL, pixel_pattern());
                send_beat(MODE_PULL, 8'($urandom()));
            end
            if (pulls == drain_cap) return;
        end
        if ($urandom_range(0, 1)) begin
            send_beat(MODE_PULL, 8'($urandom()));
            send_beat(MODE_PIXEL, pixel_pattern());
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: the prologue comes out while filling, then pulls give nothing.
        repeat (5) send_beat(MODE_PULL, 8'hFF);
        send_beat(MODE_PIXEL, 8'h5A);
        send_beat(MODE_PIXEL, 8'hA5);

        // Zero width and height act as one byte by one row; extra beats hit the idle phases.
        configure(11'd0, 16'd0);
        send_beat(MODE_PIXEL, 8'h00);
        send_beat(MODE_PIXEL, 8'hFF);
        repeat (35) send_beat(MODE_PULL, 8'h00);
        send_beat(MODE_PIXEL, 8'h00);

        gaps_on = 1'b1;
        configure(11'd2047, 16'd1);
        run_image(1, 16);
        configure(11'd335, 16'd1);
        run_image(1, 16);
        configure(11'd7, 16'd25);
        run_image(2, NO_CAP);
        configure(11'd8, 16'hFFFF);
        run_image(2, NO_CAP);

        while (beats_counted < ITEM_TARGET) begin
            gaps_on = (beats_counted < ITEM_TARGET - 120) && ($urandom_range(0, 3) != 0);
            configure(11'($urandom_range(0, 39)),
                      ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 60)));
            run_image(1, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 80) : NO_CAP);
        end

        settle();
        if (printer_stream.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
